// ----- hw/rtl/bp16_pkg.sv -----
// Shared types and constants for the 16-bit posit (ES = 3) decoder.
// Used by bp16_core and bposit16_decode; depends on nothing else.

package bp16_pkg;

  localparam int CODE_W  = 16;  // raw posit code
  localparam int BODY_W  = 15;  // code without its sign bit
  localparam int ES_BITS = 3;   // exponent field width
  localparam int SIG_W   = 11;  // significand with hidden one
  localparam int EXP_W   = 8;   // binary exponent, two's complement
  localparam int RUN_W   = 4;   // regime run length, 1..15
  localparam int K_W     = 6;   // regime value k, -14..14

  localparam logic [RUN_W-1:0] MAX_RUN = 4'd14;

  typedef struct packed {
    logic                    sign_bit;
    logic [SIG_W-1:0]        significand;
    logic signed [EXP_W-1:0] exponent;
  } result_t;

endpackage

// ----- hw/rtl/bp16_core.sv -----
// Combinational decode of one posit code into sign, significand and exponent.
// Depends on bp16_pkg for widths and the result struct.

module bp16_core (
  input  logic [bp16_pkg::CODE_W-1:0] code,
  output bp16_pkg::result_t           res
);

  logic                            neg;
  logic [bp16_pkg::BODY_W-1:0]     body;
  logic [bp16_pkg::BODY_W-1:0]     norm;
  logic                            lead;
  logic [bp16_pkg::RUN_W-1:0]      run;
  logic [bp16_pkg::RUN_W-1:0]      remaining;
  logic [bp16_pkg::RUN_W-1:0]      fw;
  logic [1:0]                      ew;
  logic [bp16_pkg::BODY_W-2:0]     tail;
  logic [bp16_pkg::BODY_W-2:0]     tail_sh;
  logic [bp16_pkg::ES_BITS-1:0]    emask;
  logic [bp16_pkg::ES_BITS-1:0]    ebits;
  logic [bp16_pkg::SIG_W-1:0]      fmask;
  logic [bp16_pkg::SIG_W-1:0]      mant;
  logic [bp16_pkg::K_W-1:0]        k;
  logic signed [bp16_pkg::EXP_W:0] e2;

  assign neg  = code[bp16_pkg::CODE_W-1];
  assign body = neg ? (~code[bp16_pkg::BODY_W-1:0] + 15'd1) : code[bp16_pkg::BODY_W-1:0];

  // Inverting a run of ones turns every regime into a run of leading zeros.
  assign lead = body[bp16_pkg::BODY_W-1];
  assign norm = lead ? ~body : body;

  // Leading-zero count over the 14 bits below the first regime bit.
  always_comb begin
    run = bp16_pkg::RUN_W'(bp16_pkg::BODY_W);
    for (int i = 0; i < bp16_pkg::BODY_W - 1; i++) begin
      if (norm[i]) begin
        run = bp16_pkg::MAX_RUN - bp16_pkg::RUN_W'(i);
      end
    end
  end

  assign k = lead ? ({2'b00, run} - 6'd1) : (6'd0 - {2'b00, run});
  assign remaining = (run >= bp16_pkg::MAX_RUN) ? 4'd0 : (bp16_pkg::MAX_RUN - run);

  assign tail = body[bp16_pkg::BODY_W-2:0] & ((14'd1 << remaining) - 14'd1);
  assign ew   = (remaining >= 4'd3) ? 2'd3 : remaining[1:0];
  assign fw   = remaining - {2'b00, ew};

  // Exponent bits cut off by the end of the word are read as zeros.
  assign tail_sh = tail >> fw;
  assign emask   = (3'd1 << ew) - 3'd1;
  assign ebits   = (tail_sh[bp16_pkg::ES_BITS-1:0] & emask) << (2'd3 - ew);

  assign fmask = (11'd1 << fw) - 11'd1;
  assign mant  = (11'd1 << fw) | (tail[bp16_pkg::SIG_W-1:0] & fmask);

  assign e2 = $signed({k, 3'b000}) + $signed({6'b000000, ebits})
              - $signed({5'b00000, fw});

  always_comb begin
    if (body == '0) begin
      res = '0;
    end else begin
      res.sign_bit    = neg;
      res.significand = mant;
      res.exponent    = e2[bp16_pkg::EXP_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/bposit16_decode.sv -----
// Top level of the 16-bit posit (ES = 3) decoder: input and result registers
// around the decode logic. Depends on bp16_pkg and bp16_core.
//
//   channel   direction  tdata fields (lowest bit first)
//   s_axis    in         code[15:0]
//   m_axis    out        sign_bit[0], significand[11:1], exponent[19:12], zeros[23:20]
//
// Each beat passes through two register stages, the input and result registers,
// with the single decode pass between them; one beat is taken every cycle
// while the output is not stalled. Reset clears both valid flags. When the
// output is stalled, the result register holds, and s_tready falls only once
// the input register is full as well.

module bposit16_decode (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // code[15:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // sign_bit, significand[10:0], exponent[7:0], pad
);

  logic                         in_valid;
  logic [bp16_pkg::CODE_W-1:0]  in_code;
  bp16_pkg::result_t            dec;
  bp16_pkg::result_t            result;
  logic                         advance;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_code <= s_tdata;
    end
  end

  bp16_core u_core (
    .code (in_code),
    .res  (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= dec;
    end
  end

  assign m_tdata = {4'b0000, result.exponent, result.significand, result.sign_bit};

endmodule
